// ===== rtl/sdt2i_pkg.sv =====
`default_nettype none

package sdt2i_pkg;

    // character codes seen by the parser
    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    // fixed widths of the stream payloads
    localparam int CHAR_BITS  = 8;
    localparam int VALUE_BITS = 32;

    // one finished result item
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  error;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/strict_decimal_text_to_int32.sv =====
`default_nettype none

// Channel   Dir  tdata (low bit up)   tuser      tlast
// s_        in   char_code[7:0]       -          -
// m_        out  value[31:0]          error[0]   -
//
// One byte is accepted per cycle, every cycle, as long as results drain.
// A byte is held in the input register; from there the parse step updates
// the state, and a terminator that advances loads the result register,
// whose valid flag drives m_tvalid.
// Only a terminator can stall, and only while an earlier result still waits
// in the result register. Reset (aresetn low) restarts the whitespace phase.
module strict_decimal_text_to_int32 #(
    parameter int RESULT_BITS = 32
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // char_code[7:0]
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [31:0] m_tdata,  // value[31:0]
    output logic       m_tuser    // error[0]
);

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGITS,
        PH_BAD
    } phase_t;

    localparam int AW = RESULT_BITS + 1;
    localparam logic [AW-1:0] LIM = AW'(1) << (RESULT_BITS - 1);
    localparam logic [AW-1:0] LIM_DIV10 = LIM / 10;

    // input register
    logic                              in_valid_reg;
    logic [sdt2i_pkg::CHAR_BITS-1:0]   char_reg;

    // parse state
    phase_t                 phase_reg, phase_next;
    logic                   neg_reg, neg_next;
    logic [RESULT_BITS-1:0] acc_reg, acc_next;
    logic                   syn_reg, syn_next;
    logic                   rng_reg, rng_next;

    // result register
    logic                   out_valid_reg;
    sdt2i_pkg::result_t     res_reg, res_next;

    logic          is_term, is_space, is_digit, advance;
    logic [3:0]    digit;
    logic [AW-1:0] acc_w, prod, dig_acc;
    logic          dig_sat;
    logic [RESULT_BITS-1:0] signed_val;
    logic [63:0]   val_wide;

    // byte classes
    assign is_term  = (char_reg == sdt2i_pkg::CHAR_NUL);
    assign is_space = (char_reg == sdt2i_pkg::CHAR_SPACE) ||
                      (char_reg >= sdt2i_pkg::CHAR_TAB && char_reg <= sdt2i_pkg::CHAR_CR);
    assign is_digit = (char_reg >= sdt2i_pkg::CHAR_ZERO) &&
                      (char_reg <= sdt2i_pkg::CHAR_NINE);
    assign digit    = 4'(char_reg - sdt2i_pkg::CHAR_ZERO);

    // saturating multiply by ten and add
    assign acc_w   = {1'b0, acc_reg};
    assign prod    = (acc_w << 3) + (acc_w << 1) + AW'(digit);
    assign dig_sat = (acc_w > LIM_DIV10) || (prod >= LIM);
    assign dig_acc = dig_sat ? LIM : prod;

    // handshake: a terminator waits for the result register to free up
    assign advance  = in_valid_reg && (!is_term || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // signed result, masked to RESULT_BITS, then fit to the 32-bit field
    assign signed_val = neg_reg ? (RESULT_BITS'(0) - acc_reg) : acc_reg;
    assign val_wide   = 64'(signed_val);

    // parse step
    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        syn_next   = syn_reg;
        rng_next   = rng_reg;
        res_next.error = syn_reg || rng_reg || (phase_reg != PH_DIGITS);
        res_next.value = res_next.error ? '0 : val_wide[sdt2i_pkg::VALUE_BITS-1:0];
        if (is_term) begin
            phase_next = PH_SPACE;
            neg_next   = 1'b0;
            acc_next   = '0;
            syn_next   = 1'b0;
            rng_next   = 1'b0;
        end else begin
            unique case (phase_reg)
                PH_SPACE: begin
                    if (is_space) begin
                        phase_next = PH_SPACE;
                    end else if (char_reg == sdt2i_pkg::CHAR_PLUS) begin
                        phase_next = PH_SIGN;
                    end else if (char_reg == sdt2i_pkg::CHAR_MINUS) begin
                        neg_next   = 1'b1;
                        phase_next = PH_SIGN;
                    end else if (is_digit) begin
                        acc_next   = dig_acc[RESULT_BITS-1:0];
                        rng_next   = rng_reg || dig_sat;
                        phase_next = PH_DIGITS;
                    end else begin
                        syn_next   = 1'b1;
                        phase_next = PH_BAD;
                    end
                end
                PH_SIGN, PH_DIGITS: begin
                    if (is_digit) begin
                        acc_next   = dig_acc[RESULT_BITS-1:0];
                        rng_next   = rng_reg || dig_sat;
                        phase_next = PH_DIGITS;
                    end else begin
                        syn_next   = 1'b1;
                        phase_next = PH_BAD;
                    end
                end
                default: begin
                    syn_next = 1'b1;
                end
            endcase
        end
    end

    // input register, state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_SPACE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            syn_reg       <= 1'b0;
            rng_reg       <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
                char_reg     <= s_tdata;
            end
            if (advance) begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                syn_reg   <= syn_next;
                rng_reg   <= rng_next;
            end
            if (advance && is_term) begin
                out_valid_reg <= 1'b1;
                res_reg       <= res_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg.value;
    assign m_tuser  = res_reg.error;

endmodule

`default_nettype wire
